// ===== rtl/knps_pkg.sv =====
// Shared types and constants for the nearest point selector.
package knps_pkg;

   // Field widths
   localparam int COORD_W   = 24;
   localparam int ID_W      = 16;
   localparam int MAG_W     = 24;
   localparam int SQ_W      = 48;
   localparam int DIST_W    = 50;
   localparam int CNT_W     = 7;
   localparam int RANK_W    = 6;
   localparam int CSR_IDX_W = 2;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MAX_TARGETS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_X    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_Y    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_Z    = 2'd3;

   // One stored point: id and squared distance to the origin
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [DIST_W-1:0] sq_dist;
   } knps_point_type;

   // One queue entry between front and back
   typedef struct packed {
      knps_point_type point;
      logic           last;
   } knps_entry_type;

endpackage

// ===== rtl/k_nearest_point_select.sv =====
// Top level of the nearest point selector: configuration registers and part wiring.
// Points are taken one beat per cycle while the queue between the distance front end
// and the selection back end has room (QUEUE_DEPTH entries, distance stages A and B
// ahead of it). After the last point of a set, the back end emits results from its
// point store, which has a single registered read port: in arrival order each result
// takes one store read; when selecting the max_targets nearest of n points, each
// result takes one store read per point and scan. Points of the next set keep
// entering the queue meanwhile and stall once it is full, counting points in flight.
// Points beyond MAX_POINTS in a set are dropped and flagged by rsp_overflow. The
// store needs no clearing pass after reset; configuration writes are always ready.
module k_nearest_point_select #(
   parameter int MAX_POINTS  = 64,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [knps_pkg::ID_W-1:0]             req_point_id,
   input  logic signed [knps_pkg::COORD_W-1:0]   req_pos_x,
   input  logic signed [knps_pkg::COORD_W-1:0]   req_pos_y,
   input  logic signed [knps_pkg::COORD_W-1:0]   req_pos_z,
   input  logic                                  req_last_point,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [knps_pkg::ID_W-1:0]             rsp_chosen_id,
   output logic [knps_pkg::RANK_W-1:0]           rsp_rank,
   output logic                                  rsp_overflow,
   output logic                                  rsp_last_result,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [knps_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [knps_pkg::COORD_W-1:0]          csr_data
);
   import knps_pkg::*;

   localparam int QCW = $clog2(QUEUE_DEPTH+1);

   logic [CNT_W-1:0]          max_targets_ff;
   logic signed [COORD_W-1:0] origin_x_ff;
   logic signed [COORD_W-1:0] origin_y_ff;
   logic signed [COORD_W-1:0] origin_z_ff;

   logic                      push_valid;
   knps_entry_type            push_entry;
   logic                      head_valid;
   knps_entry_type            head_entry;
   logic                      pop;
   logic [QCW-1:0]            fill_count;

   assign csr_ready = 1'b1;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_targets_ff <= CNT_W'(1);
         origin_x_ff    <= '0;
         origin_y_ff    <= '0;
         origin_z_ff    <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_MAX_TARGETS: max_targets_ff <= csr_data[CNT_W-1:0];
            REG_ORIGIN_X:    origin_x_ff    <= csr_data;
            REG_ORIGIN_Y:    origin_y_ff    <= csr_data;
            REG_ORIGIN_Z:    origin_z_ff    <= csr_data;
            default: begin
            end
         endcase
      end
   end

   knps_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_point_id   (req_point_id),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_pos_z      (req_pos_z),
      .req_last_point (req_last_point),
      .origin_x       (origin_x_ff),
      .origin_y       (origin_y_ff),
      .origin_z       (origin_z_ff),
      .fill_count     (fill_count),
      .push_valid     (push_valid),
      .push_entry     (push_entry)
   );

   knps_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .fill_count (fill_count)
   );

   knps_back #(
      .MAX_POINTS (MAX_POINTS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_entry      (head_entry),
      .pop             (pop),
      .max_targets     (max_targets_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_chosen_id   (rsp_chosen_id),
      .rsp_rank        (rsp_rank),
      .rsp_overflow    (rsp_overflow),
      .rsp_last_result (rsp_last_result)
   );

endmodule

// ===== rtl/knps_queue.sv =====
// Short FIFO of points with their squared distances between the front and back parts.
module knps_queue #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  push_valid,
   input  knps_pkg::knps_entry_type              push_entry,
   input  logic                                  pop,
   output logic                                  head_valid,
   output knps_pkg::knps_entry_type              head_entry,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]      fill_count
);
   import knps_pkg::*;

   localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCW = $clog2(QUEUE_DEPTH+1);

   knps_entry_type         slot_ff [QUEUE_DEPTH];
   logic [QAW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0]         count_ff, count_in;
   logic                   do_pop;

   assign do_pop     = pop && (count_ff != '0);
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];
   assign fill_count = count_ff;

   // Advance pointers with explicit wrap
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == QAW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QAW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_valid && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push_valid && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold entries
   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> (count_ff < QCW'(QUEUE_DEPTH)))
      else $error("queue pushed while full");

endmodule

// ===== rtl/knps_front.sv =====
// Front part: accepts points and computes the squared distance to the origin.
module knps_front #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [knps_pkg::ID_W-1:0]             req_point_id,
   input  logic signed [knps_pkg::COORD_W-1:0]   req_pos_x,
   input  logic signed [knps_pkg::COORD_W-1:0]   req_pos_y,
   input  logic signed [knps_pkg::COORD_W-1:0]   req_pos_z,
   input  logic                                  req_last_point,
   input  logic signed [knps_pkg::COORD_W-1:0]   origin_x,
   input  logic signed [knps_pkg::COORD_W-1:0]   origin_y,
   input  logic signed [knps_pkg::COORD_W-1:0]   origin_z,
   input  logic [$clog2(QUEUE_DEPTH+1)-1:0]      fill_count,
   output logic                                  push_valid,
   output knps_pkg::knps_entry_type              push_entry
);
   import knps_pkg::*;

   localparam int QCW = $clog2(QUEUE_DEPTH+1);

   logic               accept;
   logic [QCW:0]       busy;

   // Stage A: absolute differences
   logic               va_ff;
   logic [ID_W-1:0]    id_a_ff;
   logic               last_a_ff;
   logic [MAG_W-1:0]   mag_x_ff, mag_y_ff, mag_z_ff;
   logic [MAG_W-1:0]   mag_x_in, mag_y_in, mag_z_in;

   // Stage B: squares
   logic               vb_ff;
   logic [ID_W-1:0]    id_b_ff;
   logic               last_b_ff;
   logic [SQ_W-1:0]    sq_x_ff, sq_y_ff, sq_z_ff;

   function automatic logic [MAG_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                 input logic [COORD_W-1:0] b);
      logic [COORD_W:0] d;
      logic [COORD_W:0] m;
      d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      m = d[COORD_W] ? (~d + 1'b1) : d;
      return m[MAG_W-1:0];
   endfunction

   // Stall when the queue could not take every point in flight
   assign busy      = {1'b0, fill_count} + (QCW+1)'(va_ff) + (QCW+1)'(vb_ff);
   assign req_stall = (busy >= (QCW+1)'(QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;

   assign mag_x_in = abs_diff(req_pos_x, origin_x);
   assign mag_y_in = abs_diff(req_pos_y, origin_y);
   assign mag_z_in = abs_diff(req_pos_z, origin_z);

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         va_ff <= accept;
         vb_ff <= va_ff;
      end
   end

   // Advance payload through both stages
   always_ff @(posedge clock) begin
      id_a_ff   <= req_point_id;
      last_a_ff <= req_last_point;
      mag_x_ff  <= mag_x_in;
      mag_y_ff  <= mag_y_in;
      mag_z_ff  <= mag_z_in;
      id_b_ff   <= id_a_ff;
      last_b_ff <= last_a_ff;
      sq_x_ff   <= mag_x_ff * mag_x_ff;
      sq_y_ff   <= mag_y_ff * mag_y_ff;
      sq_z_ff   <= mag_z_ff * mag_z_ff;
   end

   // Sum the squares into the queue entry
   assign push_valid               = vb_ff;
   assign push_entry.point.id      = id_b_ff;
   assign push_entry.point.sq_dist = DIST_W'(sq_x_ff) + DIST_W'(sq_y_ff) + DIST_W'(sq_z_ff);
   assign push_entry.last          = last_b_ff;

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      busy <= (QCW+1)'(QUEUE_DEPTH))
      else $error("points in flight exceed queue room");

endmodule

// ===== rtl/knps_back.sv =====
// Back part: stores a set of points and emits the nearest ones, nearest first, or all in arrival order if few enough.
module knps_back #(
   parameter int MAX_POINTS = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              head_valid,
   input  knps_pkg::knps_entry_type          head_entry,
   output logic                              pop,
   input  logic [knps_pkg::CNT_W-1:0]        max_targets,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [knps_pkg::ID_W-1:0]         rsp_chosen_id,
   output logic [knps_pkg::RANK_W-1:0]       rsp_rank,
   output logic                              rsp_overflow,
   output logic                              rsp_last_result
);
   import knps_pkg::*;

   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam logic [CNT_W-1:0] MAXP = CNT_W'(MAX_POINTS);

   typedef enum logic [2:0] {
      ST_LOAD = 3'b001,
      ST_SCAN = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               ovf_ff, ovf_in;
   logic               run_ovf_ff, run_ovf_in;
   logic [CNT_W-1:0]   n_ff, n_in;
   logic [CNT_W-1:0]   total_ff, total_in;
   logic               pass_ff, pass_in;
   logic [CNT_W-1:0]   k_ff, k_in;
   logic [CNT_W-1:0]   i_ff, i_in;
   logic [CNT_W-1:0]   end_ff, end_in;
   logic [MAX_POINTS-1:0] taken_ff, taken_in;

   logic               rd_valid_ff, rd_valid_in;
   logic [AW-1:0]      rd_idx_ff, rd_idx_in;
   knps_point_type     rd_entry_ff;

   logic               found_ff, found_in;
   logic [DIST_W-1:0]  best_d_ff, best_d_in;
   logic [ID_W-1:0]    best_id_ff, best_id_in;
   logic [AW-1:0]      best_idx_ff, best_idx_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]    rsp_id_ff, rsp_id_in;
   logic [RANK_W-1:0]  rsp_rank_ff, rsp_rank_in;
   logic               rsp_ovf_ff, rsp_ovf_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               room;
   logic               wr_en;
   logic [CNT_W-1:0]   n_new;
   logic               pass_new;
   logic               rsp_load;

   knps_point_type     store_ff [MAX_POINTS];

   assign room  = (cnt_ff < MAXP);
   assign pop   = (state_ff == ST_LOAD) && head_valid;
   assign wr_en = pop && room;
   assign n_new = room ? cnt_ff + 1'b1 : cnt_ff;
   assign pass_new = (n_new <= max_targets);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      run_ovf_in   = run_ovf_ff;
      n_in         = n_ff;
      total_in     = total_ff;
      pass_in      = pass_ff;
      k_in         = k_ff;
      i_in         = i_ff;
      end_in       = end_ff;
      taken_in     = taken_ff;
      rd_valid_in  = 1'b0;
      rd_idx_in    = i_ff[AW-1:0];
      found_in     = found_ff;
      best_d_in    = best_d_ff;
      best_id_in   = best_id_ff;
      best_idx_in  = best_idx_ff;
      rsp_load     = 1'b0;
      rsp_id_in    = rsp_id_ff;
      rsp_rank_in  = rsp_rank_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_last_in  = rsp_last_ff;

      // Keep the nearest untaken point seen so far; earlier wins on ties
      if (rd_valid_ff && !taken_ff[rd_idx_ff] &&
          (!found_ff || (rd_entry_ff.sq_dist < best_d_ff))) begin
         found_in    = 1'b1;
         best_d_in   = rd_entry_ff.sq_dist;
         best_id_in  = rd_entry_ff.id;
         best_idx_in = rd_idx_ff;
      end

      case (state_ff)
         ST_LOAD: begin
            if (pop) begin
               if (room) begin
                  cnt_in = cnt_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               // Close the set on its last point
               if (head_entry.last) begin
                  cnt_in = '0;
                  ovf_in = 1'b0;
                  if (pass_new || (max_targets != '0)) begin
                     state_in   = ST_SCAN;
                     run_ovf_in = ovf_ff || !room;
                     n_in       = n_new;
                     pass_in    = pass_new;
                     total_in   = pass_new ? n_new : max_targets;
                     k_in       = '0;
                     i_in       = '0;
                     end_in     = pass_new ? CNT_W'(1) : n_new;
                     taken_in   = '0;
                     found_in   = 1'b0;
                  end
               end
            end
         end
         ST_SCAN: begin
            // Issue one read a cycle, then wait for the last compare
            if (i_ff < end_ff) begin
               rd_valid_in = 1'b1;
               i_in        = i_ff + 1'b1;
            end else if (!rd_valid_ff) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load    = 1'b1;
               rsp_id_in   = best_id_ff;
               rsp_rank_in = k_ff[RANK_W-1:0];
               rsp_ovf_in  = run_ovf_ff;
               rsp_last_in = ((k_ff + 1'b1) == total_ff);
               taken_in[best_idx_ff] = 1'b1;
               k_in        = k_ff + 1'b1;
               found_in    = 1'b0;
               if ((k_ff + 1'b1) == total_ff) begin
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_SCAN;
                  i_in     = pass_ff ? k_ff + 1'b1 : '0;
                  end_in   = pass_ff ? k_ff + 2'd2 : n_ff;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase

      // Drop a taken beat, hold a stalled one
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         rd_valid_ff  <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         taken_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         rd_valid_ff  <= rd_valid_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         taken_ff     <= taken_in;
      end
   end

   always_ff @(posedge clock) begin
      run_ovf_ff  <= run_ovf_in;
      n_ff        <= n_in;
      total_ff    <= total_in;
      pass_ff     <= pass_in;
      k_ff        <= k_in;
      i_ff        <= i_in;
      end_ff      <= end_in;
      rd_idx_ff   <= rd_idx_in;
      best_d_ff   <= best_d_in;
      best_id_ff  <= best_id_in;
      best_idx_ff <= best_idx_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_rank_ff <= rsp_rank_in;
      rsp_ovf_ff  <= rsp_ovf_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Point store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[cnt_ff[AW-1:0]] <= head_entry.point;
      end
      rd_entry_ff <= store_ff[i_ff[AW-1:0]];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_chosen_id   = rsp_id_ff;
   assign rsp_rank        = rsp_rank_ff;
   assign rsp_overflow    = rsp_ovf_ff;
   assign rsp_last_result = rsp_last_ff;

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (i_ff <= end_ff))
      else $error("scan index ran past its end");

   a_emit_has_best: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> found_ff)
      else $error("emitting without a selected point");

endmodule
